// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor controller package
// Beat types, request codes and screen/memory constants.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int unsigned ScreenCols = 32;
	localparam int unsigned ScreenRows = 24;

	localparam logic [4:0]  LastRow    = 5'(ScreenRows - 1);
	localparam logic [4:0]  LastCol    = 5'(ScreenCols - 1);
	localparam logic [14:0] BitmapBase = 15'h4000;
	localparam logic [14:0] AttrBase   = 15'h5800;
	localparam logic [13:0] FontBase   = 14'h3d00;
	localparam logic [5:0]  TabMask    = 6'h38;
	localparam logic [5:0]  TabStep    = 6'd8;
	localparam logic [7:0]  AttrReset  = 8'd7;

	localparam logic [7:0]  CharBs     = 8'd8;
	localparam logic [7:0]  CharTab    = 8'd9;
	localparam logic [7:0]  CharLf     = 8'd10;
	localparam logic [7:0]  CharCr     = 8'd13;
	localparam logic [7:0]  CharSpace  = 8'd32;
	localparam logic [6:0]  CharQuery  = 7'h3f;

	// register index as decoded from paddr[2]
	localparam logic        RegTextAttribute = 1'b0;

	typedef enum logic [1:0] {
		ActPutChar   = 2'd0,
		ActSetCursor = 2'd1,
		ActClear     = 2'd2
	} tcc_action_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [7:0] new_column;
		logic [7:0] new_row;
	} tcc_in_t;

	typedef struct packed {
		logic        write_cell;
		logic [4:0]  cell_column;
		logic [4:0]  cell_row;
		logic [14:0] bitmap_address;
		logic [14:0] attr_address;
		logic [13:0] font_address;
		logic [7:0]  cell_attribute;
		logic        scroll_up;
		logic        clear_screen;
		logic [4:0]  cursor_column_out;
		logic [4:0]  cursor_row_out;
	} tcc_out_t;

	typedef struct packed {
		logic [4:0] row;
		logic [4:0] column;
	} tcc_cursor_t;

endpackage

// ----- hw/rtl/tcc_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface tcc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tcc_step.sv -----
// ----------------------------------------------------------------------------
// Cursor step
// Decodes one request, forms the cell-write addresses and the next cursor.
// ----------------------------------------------------------------------------
module tcc_step
	import tcc_pkg::*;
(
	input  tcc_cursor_t cursor,
	input  tcc_in_t     item,
	input  logic [7:0]  attribute,
	output tcc_cursor_t cursor_next,
	output tcc_out_t    result
);

	logic [5:0] col_inc;
	logic [5:0] col_tab;
	logic [4:0] row_inc;
	logic [6:0] glyph;
	logic [6:0] glyph_off;
	logic       line_feed;
	tcc_cursor_t nxt;
	tcc_out_t    res;

	assign col_inc   = {1'b0, cursor.column} + 6'd1;
	assign col_tab   = ({1'b0, cursor.column} + TabStep) & TabMask;
	assign row_inc   = cursor.row + 5'd1;
	assign glyph     = item.char_code[7] ? CharQuery : item.char_code[6:0];
	assign glyph_off = glyph - 7'(CharSpace);

	always_comb begin
		nxt = cursor;
		res = '0;
		res.cell_attribute = attribute;
		line_feed = 1'b0;

		case (item.action)
			ActPutChar: begin
				case (item.char_code)
					CharLf: line_feed = 1'b1;
					CharCr: nxt.column = '0;
					CharTab: begin
						if (col_tab[5]) line_feed = 1'b1;
						else nxt.column = col_tab[4:0];
					end
					CharBs: begin
						if (cursor.column != '0) begin
							nxt.column = cursor.column - 5'd1;
						end else if (cursor.row != '0) begin
							nxt.row    = cursor.row - 5'd1;
							nxt.column = LastCol;
						end
					end
					default: begin
						if (item.char_code >= CharSpace) begin
							res.write_cell     = 1'b1;
							res.cell_column    = cursor.column;
							res.cell_row       = cursor.row;
							// interleaved layout: third, scanline-row, column
							res.bitmap_address = BitmapBase + {2'b00, cursor.row[4:3], 3'b000,
								cursor.row[2:0], cursor.column};
							res.attr_address   = AttrBase + {5'b00000, cursor.row, cursor.column};
							res.font_address   = FontBase + {4'b0000, glyph_off, 3'b000};
							if (col_inc[5]) line_feed = 1'b1;
							else nxt.column = col_inc[4:0];
						end
					end
				endcase
			end
			ActSetCursor: begin
				if (item.new_column < 8'(ScreenCols) && item.new_row < 8'(ScreenRows)) begin
					nxt.column = item.new_column[4:0];
					nxt.row    = item.new_row[4:0];
				end
			end
			ActClear: begin
				res.clear_screen = 1'b1;
				nxt = '0;
			end
			default: ;
		endcase

		if (line_feed) begin
			nxt.column = '0;
			if (cursor.row == LastRow) res.scroll_up = 1'b1;
			else nxt.row = row_inc;
		end

		res.cursor_column_out = nxt.column;
		res.cursor_row_out    = nxt.row;
	end

	assign cursor_next = nxt;
	assign result      = res;

endmodule

// ----- hw/rtl/text_console_cursor_controller.sv -----
// ----------------------------------------------------------------------------
// Text console cursor controller
// Cursor tracking and cell-write command generation for a 32x24 text screen.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle and returns one result beat for each,
// through the request register and then the result register. The rate
// is one beat per cycle, set by the cursor register loop through the step
// logic; a stalled result holds the request register, and the input stalls
// only when both are full and rsp.ready is low. The text attribute register
// sits at APB byte address 0 and resets to 7; write it only while no beat is in flight.
module text_console_cursor_controller
	import tcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tcc_stream_if.sink   req,
	tcc_stream_if.source rsp
);

	logic        valid_s1;
	tcc_in_t     item_s1;
	logic        rsp_valid_q;
	tcc_out_t    result_q;
	tcc_cursor_t cursor_q;
	tcc_cursor_t cursor_next;
	tcc_out_t    result;
	logic [7:0]  attr_q;
	logic        advance;
	logic        req_fire;

	assign advance  = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire = req.valid && req.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = result_q;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegTextAttribute) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= AttrReset;
		end else if (psel && penable && pwrite && paddr[2] == RegTextAttribute) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcc_step u_step (
		.cursor      (cursor_q),
		.item        (item_s1),
		.attribute   (attr_q),
		.cursor_next (cursor_next),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			cursor_q    <= '0;
		end else begin
			if (req_fire) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;

			if (advance) cursor_q <= cursor_next;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) item_s1 <= req.data;
		if (advance) result_q <= result;
	end

endmodule

// ----- hw/rtl/tcc_checker.sv -----
// ----------------------------------------------------------------------------
// Text console cursor controller checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcc_checker
	import tcc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input tcc_out_t rsp_data
);

	// a drawn cell's attribute address agrees with its position
	`ASSERT_IMPLIES(a_attr_addr, clk, arst_n, rsp_valid && rsp_data.write_cell, rsp_data.attr_address == AttrBase + {5'b00000, rsp_data.cell_row, rsp_data.cell_column})

	// printing in the last column of a non-final row wraps to the next row
	`ASSERT_IMPLIES(a_wrap, clk, arst_n, rsp_valid && rsp_data.write_cell && rsp_data.cell_column == LastCol && rsp_data.cell_row != LastRow, rsp_data.cursor_column_out == '0 && rsp_data.cursor_row_out == rsp_data.cell_row + 5'd1 && !rsp_data.scroll_up)

	// clear homes the cursor and draws nothing
	`ASSERT_IMPLIES(a_clear, clk, arst_n, rsp_valid && rsp_data.clear_screen, rsp_data.cursor_column_out == '0 && rsp_data.cursor_row_out == '0 && !rsp_data.write_cell && !rsp_data.scroll_up)

	// a stalled beat holds
	`ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind text_console_cursor_controller tcc_checker u_tcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
